### rtl/core/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants of the move-to-front coder: register indexes,
// controller states, datapath operations and the command/status bundles.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DATA_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MULT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 2'd3;

    localparam logic [DATA_W-1:0] RST_TABLE_SIZE = 7'd127;
    localparam logic [DATA_W-1:0] RST_MULT       = 7'd1;
    localparam logic [DATA_W-1:0] RST_OFFSET     = 7'd0;

    typedef enum logic [3:0] {
        S_LOAD,
        S_REDUCE,
        S_FILL,
        S_IDLE,
        S_SEARCH,
        S_PRIME,
        S_SHIFT,
        S_FRONT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_REDUCE_LOAD,
        OP_REDUCE,
        OP_FILL_START,
        OP_FILL,
        OP_LOOKUP,
        OP_SEARCH,
        OP_PRIME,
        OP_SHIFT,
        OP_FRONT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic dir;
        logic in_range;
        logic reduce_done;
        logic cnt_last;
        logic hit;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/mtf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer of the move-to-front coder: list rebuild, search, shift of the
// list by one place and hand-off of the result item.
// ----------------------------------------------------------------------------
module mtf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mtf_pkg::t_stat i_stat,
    output mtf_pkg::t_cmd  o_cmd
);

    mtf_pkg::t_state r_state;
    mtf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtf_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = mtf_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            mtf_pkg::S_LOAD: begin
                o_cmd.op = mtf_pkg::OP_REDUCE_LOAD;
                n_state  = mtf_pkg::S_REDUCE;
            end
            mtf_pkg::S_REDUCE: begin
                if (i_stat.reduce_done) begin
                    o_cmd.op = mtf_pkg::OP_FILL_START;
                    n_state  = mtf_pkg::S_FILL;
                end else begin
                    o_cmd.op = mtf_pkg::OP_REDUCE;
                end
            end
            mtf_pkg::S_FILL: begin
                o_cmd.op = mtf_pkg::OP_FILL;
                if (i_stat.cnt_last) begin
                    n_state = mtf_pkg::S_IDLE;
                end
            end
            mtf_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = mtf_pkg::OP_LOOKUP;
                    if (i_stat.dir && !i_stat.in_range) begin
                        n_state = mtf_pkg::S_DONE;
                    end else begin
                        n_state = mtf_pkg::S_SEARCH;
                    end
                end
            end
            mtf_pkg::S_SEARCH: begin
                o_cmd.op = mtf_pkg::OP_SEARCH;
                if (i_stat.hit) begin
                    n_state = mtf_pkg::S_PRIME;
                end else if (i_stat.cnt_last) begin
                    n_state = mtf_pkg::S_DONE;
                end
            end
            mtf_pkg::S_PRIME: begin
                o_cmd.op = mtf_pkg::OP_PRIME;
                if (i_stat.cnt_zero) begin
                    n_state = mtf_pkg::S_FRONT;
                end else begin
                    n_state = mtf_pkg::S_SHIFT;
                end
            end
            mtf_pkg::S_SHIFT: begin
                o_cmd.op = mtf_pkg::OP_SHIFT;
                if (i_stat.cnt_one) begin
                    n_state = mtf_pkg::S_FRONT;
                end
            end
            mtf_pkg::S_FRONT: begin
                o_cmd.op = mtf_pkg::OP_FRONT;
                n_state  = mtf_pkg::S_DONE;
            end
            mtf_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mtf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtf_pkg::S_LOAD;
            end
        endcase
        // restart the rebuild on any register write
        if (i_stat.cfg_wr) begin
            o_cmd.op = mtf_pkg::OP_NONE;
            n_state  = mtf_pkg::S_LOAD;
        end
    end

    assign o_stall = (r_state != mtf_pkg::S_IDLE) || i_stat.cfg_wr;

endmodule

### rtl/core/mtf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_dpath
// Datapath of the move-to-front coder: configuration registers, symbol list
// memory, affine list generator, search counter and result register.
// ----------------------------------------------------------------------------
module mtf_dpath #(
    parameter int LIST_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mtf_pkg::t_cmd                  i_cmd,
    output mtf_pkg::t_stat                 o_stat,
    input  logic [mtf_pkg::DATA_W-1:0]     i_symbol,
    input  logic                           i_cfg_valid,
    input  logic [mtf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtf_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [mtf_pkg::DATA_W-1:0]     o_result,
    output logic                           o_error
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int DW = mtf_pkg::DATA_W;

    logic [DW-1:0] r_mem [LIST_DEPTH];
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    logic          w_we;
    logic [DW-1:0] w_wdata;

    logic          r_dir;
    logic [DW-1:0] r_size;
    logic [DW-1:0] r_mult;
    logic [DW-1:0] r_offset;

    logic [DW-1:0] r_mred;
    logic [DW-1:0] r_ored;
    logic [DW-1:0] r_val;
    logic [DW-1:0] n_val;
    logic [DW:0]   w_sum;
    logic [DW-1:0] r_cnt;
    logic [DW-1:0] r_key;
    logic [DW-1:0] r_mv;
    logic [DW-1:0] r_res;
    logic          r_err;

    logic          r_out_valid;
    logic [DW-1:0] r_out_res;
    logic          r_out_err;

    logic [DW-1:0] w_n;
    logic          w_hit;

    always_comb begin
        if (r_size < DW'(2)) begin
            w_n = DW'(2);
        end else if (32'(r_size) > LIST_DEPTH) begin
            w_n = DW'(LIST_DEPTH);
        end else begin
            w_n = r_size;
        end
    end

    assign w_hit = r_dir || (r_rdata == r_key);

    assign w_sum = {1'b0, r_val} + {1'b0, r_mred};
    assign n_val = (w_sum >= {1'b0, w_n}) ? DW'(w_sum - {1'b0, w_n}) : DW'(w_sum);

    always_comb begin
        w_raddr = AW'(r_cnt + DW'(1));
        w_we    = 1'b0;
        w_waddr = AW'(r_cnt);
        w_wdata = r_rdata;
        case (i_cmd.op)
            mtf_pkg::OP_LOOKUP: begin
                w_raddr = r_dir ? AW'(i_symbol) : '0;
            end
            mtf_pkg::OP_PRIME: begin
                w_raddr = AW'(r_cnt - DW'(1));
            end
            mtf_pkg::OP_SHIFT: begin
                w_raddr = AW'(r_cnt - DW'(2));
                w_we    = 1'b1;
            end
            mtf_pkg::OP_FILL: begin
                w_we    = 1'b1;
                w_wdata = r_val;
            end
            mtf_pkg::OP_FRONT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_mv;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= 1'b0;
            r_size      <= mtf_pkg::RST_TABLE_SIZE;
            r_mult      <= mtf_pkg::RST_MULT;
            r_offset    <= mtf_pkg::RST_OFFSET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mtf_pkg::REG_DIRECTION:  r_dir    <= i_cfg_data[0];
                    mtf_pkg::REG_TABLE_SIZE: r_size   <= i_cfg_data;
                    mtf_pkg::REG_MULT:       r_mult   <= i_cfg_data;
                    mtf_pkg::REG_OFFSET:     r_offset <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mtf_pkg::OP_REDUCE_LOAD: begin
                r_mred <= r_mult;
                r_ored <= r_offset;
            end
            mtf_pkg::OP_REDUCE: begin
                if (r_mred >= w_n) begin
                    r_mred <= r_mred - w_n;
                end
                if (r_ored >= w_n) begin
                    r_ored <= r_ored - w_n;
                end
            end
            mtf_pkg::OP_FILL_START: begin
                r_cnt <= '0;
                r_val <= r_ored;
            end
            mtf_pkg::OP_FILL: begin
                r_cnt <= r_cnt + DW'(1);
                r_val <= n_val;
            end
            mtf_pkg::OP_LOOKUP: begin
                r_key <= i_symbol;
                r_res <= '0;
                r_err <= 1'b1;
                r_cnt <= r_dir ? i_symbol : '0;
            end
            mtf_pkg::OP_SEARCH: begin
                if (w_hit) begin
                    r_res <= r_dir ? r_rdata : r_cnt;
                    r_mv  <= r_rdata;
                    r_err <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + DW'(1);
                end
            end
            mtf_pkg::OP_SHIFT: begin
                r_cnt <= r_cnt - DW'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_res <= r_res;
            r_out_err <= r_err;
        end
    end

    always_comb begin
        o_stat.cfg_wr      = i_cfg_valid;
        o_stat.dir         = r_dir;
        o_stat.in_range    = i_symbol < w_n;
        o_stat.reduce_done = (r_mred < w_n) && (r_ored < w_n);
        o_stat.cnt_last    = r_cnt == (w_n - DW'(1));
        o_stat.hit         = w_hit;
        o_stat.cnt_zero    = r_cnt == '0;
        o_stat.cnt_one     = r_cnt == DW'(1);
        o_stat.out_free    = !r_out_valid || !i_stall;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_res;
    assign o_error  = r_out_err;

endmodule

### rtl/core/move_to_front_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_transform
// Move-to-front coder, one item at a time. An encode hit at list position p
// steps through search, prime, a shift of the entries ahead of p and the
// front write before the result item is loaded; a decode of position p does
// the same but finds its entry at once, an absent symbol searches the whole
// list and an out-of-range position goes straight to the load. The next item
// is taken in the cycle after the load; a stalled output item delays the load.
// Reset and every register write rebuild the list, input stalled meanwhile:
// a load step, reduction of multiplier and offset, and a fill of each entry.
// ----------------------------------------------------------------------------
module move_to_front_transform #(
    parameter int LIST_DEPTH = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mtf_pkg::DATA_W-1:0]     i_symbol,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mtf_pkg::DATA_W-1:0]     o_result,
    output logic                           o_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mtf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtf_pkg::DATA_W-1:0]     i_cfg_data
);

    mtf_pkg::t_cmd  w_cmd;
    mtf_pkg::t_stat w_stat;

    assign o_cfg_ready = i_rst_n;

    mtf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    mtf_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_symbol    (i_symbol),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_error     (o_error)
    );

endmodule

### rtl/core/mtf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_checker
// Port-level checks of the move-to-front coder, bound to the top level.
// ----------------------------------------------------------------------------
module mtf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [mtf_pkg::DATA_W-1:0]     i_symbol,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [mtf_pkg::DATA_W-1:0]     o_result,
    input logic                           o_error,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [mtf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [mtf_pkg::DATA_W-1:0]     i_cfg_data
);

    // rebuild after reset keeps the input stalled
    a_stall_after_reset: assert property (@(posedge i_clk)
        ($past(i_rst_n) == 1'b0) && i_rst_n |-> o_stall)
        else $error("input not stalled after reset");

    // a register write starts a rebuild
    a_stall_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_stall)
        else $error("input not stalled after register write");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while busy");

    // error items carry a zero result
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_result == '0)
        else $error("error item with nonzero result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result) && $stable(o_error))
        else $error("stalled output item changed");

endmodule

bind move_to_front_transform mtf_checker u_mtf_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the move-to-front coder. A list tracker keeps its
// own copy of the symbol list and the register settings, predicts position
// or symbol and the error flag for every accepted item, and checks each
// result in order. Directed settings cover identity, tiny, non-coprime and
// wrapped-offset lists; random phases then mix sizes, directions, gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DATA_W       = mtf_pkg::DATA_W;
    localparam int CFG_IDX_W    = mtf_pkg::CFG_IDX_W;
    localparam int LIST_DEPTH   = 128;
    localparam int ITEM_TARGET  = 570;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic [DATA_W-1:0] code;
        logic              error;
    } t_coded;

    class mtf_list_tracker;
        logic [DATA_W-1:0] order [LIST_DEPTH];
        bit                decoding;
        logic [DATA_W-1:0] size_reg;
        logic [DATA_W-1:0] mult_reg;
        logic [DATA_W-1:0] offset_reg;
        t_coded            pending_codes[$];
        int                mismatches;

        function new();
            decoding   = 1'b0;
            size_reg   = mtf_pkg::RST_TABLE_SIZE;
            mult_reg   = mtf_pkg::RST_MULT;
            offset_reg = mtf_pkg::RST_OFFSET;
            mismatches = 0;
            rebuild();
        endfunction

        function int live_size();
            int n;
            n = int'(size_reg);
            if (n < 2) n = 2;
            if (n > LIST_DEPTH) n = LIST_DEPTH;
            return n;
        endfunction

        function void rebuild();
            int n;
            n = live_size();
            for (int i = 0; i < LIST_DEPTH; i++)
                order[i] = (i < n) ?
                    DATA_W'((int'(mult_reg) * i + int'(offset_reg)) % n) : '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                mtf_pkg::REG_DIRECTION:  decoding   = data[0];
                mtf_pkg::REG_TABLE_SIZE: size_reg   = data;
                mtf_pkg::REG_MULT:       mult_reg   = data;
                mtf_pkg::REG_OFFSET:     offset_reg = data;
                default: ;
            endcase
            rebuild();
        endfunction

        function void note_symbol(logic [DATA_W-1:0] sym);
            int                n;
            int                hit;
            t_coded            want;
            logic [DATA_W-1:0] value;
            n = live_size();
            hit = -1;
            want.code = '0;
            want.error = 1'b1;
            if (!decoding) begin
                for (int p = 0; p < n; p++)
                    if (hit < 0 && order[p] == sym) hit = p;
                if (hit >= 0) want.code = DATA_W'(hit);
            end else if (int'(sym) < n) begin
                hit = int'(sym);
                want.code = order[hit];
            end
            if (hit >= 0) begin
                want.error = 1'b0;
                value = order[hit];
                for (int k = hit; k > 0; k--) order[k] = order[k-1];
                order[0] = value;
            end
            pending_codes.insert(pending_codes.size(), want);
        endfunction

        function void check_result(logic [DATA_W-1:0] code, logic error);
            t_coded want;
            if (pending_codes.size() == 0) begin
                $error("result with no item outstanding: result %0d error %0d",
                       code, error);
                mismatches++;
                return;
            end
            want = pending_codes[0];
            pending_codes.delete(0);
            if (code !== want.code) begin
                $error("result: expected %0d, got %0d", want.code, code);
                mismatches++;
            end
            if (error !== want.error) begin
                $error("error: expected %0d, got %0d", want.error, error);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_codes.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [DATA_W-1:0]    i_symbol    = '0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [DATA_W-1:0]    o_result;
    logic                 o_error;
    logic                 o_cfg_ready;

    mtf_list_tracker tracker = new();

    bit hold_request = 1'b0;
    bit hold_active  = 1'b0;
    bit gapless      = 1'b0;
    int items_sent   = 0;
    int results_seen = 0;
    int flagged      = 0;
    int settings_run = 1;
    int idle_cycles  = 0;

    move_to_front_transform #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_symbol    (i_symbol),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .o_error     (o_error),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_symbol(int n);
        if ($urandom_range(0, 99) < 85) return DATA_W'($urandom_range(0, n - 1));
        return DATA_W'($urandom_range(0, 127));
    endfunction

    task automatic send_symbol(logic [DATA_W-1:0] sym);
        int gap;
        i_valid  <= 1'b1;
        i_symbol <= sym;
        do @(posedge i_clk); while (o_stall);
        tracker.note_symbol(sym);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // send a batch, then hold off until every result is back
    task automatic send_batch(int syms[$]);
        foreach (syms[k]) send_symbol(DATA_W'(syms[k]));
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    task automatic write_settings(bit dir, logic [DATA_W-1:0] size,
                                  logic [DATA_W-1:0] mult, logic [DATA_W-1:0] off);
        put_reg(mtf_pkg::REG_DIRECTION, DATA_W'(dir));
        put_reg(mtf_pkg::REG_TABLE_SIZE, size);
        put_reg(mtf_pkg::REG_MULT, mult);
        put_reg(mtf_pkg::REG_OFFSET, off);
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // receiver: random stalls, calm stretches, and the requested long hold
    initial begin : receiver
        int r;
        int span;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                i_stall <= 1'b1;
                span = HOLD_CYCLES;
            end else if (r < 45) begin
                i_stall <= 1'b0;
                span = $urandom_range(1, 8);
            end else if (r < 80) begin
                i_stall <= 1'b1;
                span = $urandom_range(1, 3);
            end else if (r < 93) begin
                i_stall <= 1'b1;
                span = $urandom_range(4, 15);
            end else if (r < 97) begin
                i_stall <= 1'b0;
                span = $urandom_range(50, 150);
            end else begin
                i_stall <= 1'b1;
                span = $urandom_range(30, 80);
            end
            repeat (span) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_result(o_result, o_error);
            results_seen++;
            if (o_error) flagged++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int     r;
        int     len;
        int     size;
        bit     hold_done;
        int     syms[$];
        hold_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: identity list, encode
        send_batch('{0, 127, 126, 0, 64});
        write_settings(1'b1, 7'd127, 7'd1, 7'd0);
        send_batch('{0, 126, 127, 5});
        // sizes below two act as two
        write_settings(1'b0, 7'd0, 7'd1, 7'd0);
        send_batch('{1, 0, 2});
        write_settings(1'b1, 7'd1, 7'd127, 7'd127);
        send_batch('{0, 1, 2, 127});
        // repeated values: encode finds the one nearest the front
        write_settings(1'b0, 7'd126, 7'd2, 7'd0);
        send_batch('{2, 1, 124});
        write_settings(1'b1, 7'd10, 7'd3, 7'd125);
        send_batch('{9, 10});
        write_settings(1'b0, 7'd5, 7'd0, 7'd3);
        send_batch('{3, 4});

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10)      size = $urandom_range(0, 1);
            else if (r < 75) size = $urandom_range(2, 16);
            else if (r < 90) size = $urandom_range(17, 63);
            else             size = $urandom_range(64, 127);
            write_settings(1'($urandom_range(0, 1)), DATA_W'(size),
                           ($urandom_range(0, 9) == 0) ? DATA_W'($urandom_range(0, 1) * 127)
                                                       : DATA_W'($urandom_range(1, 126)),
                           DATA_W'($urandom_range(0, 127)));
            gapless = ($urandom_range(0, 3) == 0);
            len = $urandom_range(20, 60);
            syms.delete();
            repeat (len) syms.insert(syms.size(), int'(pick_symbol(tracker.live_size())));
            if (!hold_done) begin
                hold_request = 1'b1;
                wait (hold_active);
                hold_done = 1'b1;
                gapless = 1'b1;
            end
            send_batch(syms);
        end

        gapless = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Coded %0d items under %0d register settings; %0d results, %0d flagged.",
                 items_sent, settings_run, results_seen, flagged);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
